FILE: sv/morph_target_blend_core_defines.svh
// assertion macros for the morph target blend core
`ifndef MORPH_TARGET_BLEND_CORE_DEFINES_SVH
`define MORPH_TARGET_BLEND_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MTB_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtb check failed");

`define MTB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtb check failed");

`else

`define MTB_ASSERT_SAME(name, clk, rst, ante, cons)

`define MTB_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: sv/mtb_pkg.sv
// types, codes and blend arithmetic shared by the morph target blend core
`default_nettype none

package mtb_pkg;

   localparam int INDEX_W     = 12;
   localparam int SLOT_W      = 3;
   localparam int OP_W        = 2;
   localparam int VALUE_W     = 32;
   localparam int WEIGHT_W    = 16;
   localparam int WEIGHT_REGS = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int FRAC_SHIFT  = 12;
   localparam int PROD_W      = VALUE_W + WEIGHT_W;
   localparam int SHIFT_W     = PROD_W - FRAC_SHIFT;
   localparam int SUM_W       = SHIFT_W + 1;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef logic signed [VALUE_W-1:0]  coord_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } pos_type;

   // floor shift of the product, add to the entry, clamp to 32 bits
   function automatic coord_type blend_axis(input coord_type cur, input prod_type prod);
      logic [SHIFT_W-1:0]      sh;
      logic [SUM_W-1:0]        sum;
      logic [SUM_W-VALUE_W:0]  top;
      coord_type               res;
      sh  = prod[PROD_W-1:FRAC_SHIFT];
      sum = {{(SUM_W-VALUE_W){cur[VALUE_W-1]}}, cur} + {sh[SHIFT_W-1], sh};
      top = sum[SUM_W-1:VALUE_W-1];
      if ((&top) || !(|top)) begin
         res = sum[VALUE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         res = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(VALUE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/morph_target_blend_core.sv
// morph target blend core: vertex position store with weighted delta accumulation
//
// A request is taken when start is high and busy is low; busy then stays high
// until the block can take the next one, and a request presented during busy
// is ignored and not queued. A load writes, a read reads and an apply does a
// read-modify-write of a single entry of one 96-bit wide store (x, y, z) with
// a registered read. A load holds busy through address reduction, address and
// write. A read or an apply holds busy through address reduction, address,
// store read, and modify or return; the read result appears on the cycle after
// busy falls, for one cycle only, with rsp_valid high, and must be taken then
// since the receiver cannot stall. An apply whose slot weight is zero or
// negative or whose slot is at or beyond MORPH_SLOTS, and an unused operation
// code, are taken without raising busy. The vertex index is reduced modulo
// VERTEX_DEPTH; read_index echoes the index as given. Weights are to be
// written through the csr port only while the block is idle, which the block
// itself does not enforce; an entry must be loaded before it is read or blended.
`default_nettype none

`include "morph_target_blend_core_defines.svh"

module morph_target_blend_core #(
   parameter int VERTEX_DEPTH = 4096,
   parameter int MORPH_SLOTS  = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [mtb_pkg::OP_W-1:0]             req_operation,
   input  wire logic [mtb_pkg::INDEX_W-1:0]          req_vertex_index,
   input  wire logic [mtb_pkg::SLOT_W-1:0]           req_morph_slot,
   input  wire mtb_pkg::coord_type                   req_value_x,
   input  wire mtb_pkg::coord_type                   req_value_y,
   input  wire mtb_pkg::coord_type                   req_value_z,
   output logic                                      rsp_valid,
   output logic      [mtb_pkg::INDEX_W-1:0]          rsp_read_index,
   output mtb_pkg::coord_type                        rsp_pos_x,
   output mtb_pkg::coord_type                        rsp_pos_y,
   output mtb_pkg::coord_type                        rsp_pos_z,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mtb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mtb_pkg::WEIGHT_W-1:0]         csr_write_data
);

   import mtb_pkg::*;

   localparam int AW = $clog2(VERTEX_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_QUOT   = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;

   logic [2:0]         state_ff, state_in;
   weight_type         weight_ff [WEIGHT_REGS];
   weight_type         weight_in [WEIGHT_REGS];
   logic [OP_W-1:0]    op_ff, op_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   weight_type         wsel_ff, wsel_in;
   pos_type            val_ff, val_in;
   prod_type           prod_x_ff, prod_x_in;
   prod_type           prod_y_ff, prod_y_in;
   prod_type           prod_z_ff, prod_z_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      addr_calc;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   pos_type            rsp_pos_ff, rsp_pos_in;

   logic               accept;
   logic               slot_ok;
   weight_type         wsel;
   logic               work;
   logic               ram_we;
   pos_type            ram_wdata;
   pos_type            ram_rdata;
   pos_type            blended;

   // slot weight and whether the request needs the store at all
   assign slot_ok = {1'b0, req_morph_slot} < (SLOT_W+1)'(MORPH_SLOTS);
   assign wsel    = slot_ok ? weight_ff[req_morph_slot] : '0;
   assign work    = (req_operation == OP_LOAD) || (req_operation == OP_READ) ||
                    ((req_operation == OP_APPLY) && (wsel > 0));
   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   // weight registers
   always_comb begin
      weight_in = weight_ff;
      if (csr_write_enable && ({1'b0, csr_index} < (CSR_INDEX_W+1)'(WEIGHT_REGS))) begin
         weight_in[csr_index[SLOT_W-1:0]] = csr_write_data;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && work) begin
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            state_in = S_ADDR;
         end
         S_ADDR: begin
            state_in = (op_ff == OP_LOAD) ? S_WRITE : S_READ;
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_WRITE, S_MODIFY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // request capture and products
   always_comb begin
      op_in     = op_ff;
      index_in  = index_ff;
      wsel_in   = wsel_ff;
      val_in    = val_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      prod_z_in = prod_z_ff;
      addr_in   = addr_ff;
      if (accept) begin
         op_in    = req_operation;
         index_in = req_vertex_index;
         wsel_in  = wsel;
         val_in   = '{z: req_value_z, y: req_value_y, x: req_value_x};
      end
      if (state_ff == S_QUOT) begin
         prod_x_in = wsel_ff * val_ff.x;
         prod_y_in = wsel_ff * val_ff.y;
         prod_z_in = wsel_ff * val_ff.z;
      end
      if (state_ff == S_ADDR) begin
         addr_in = addr_calc;
      end
   end

   // index reduction modulo the store depth
   if (VERTEX_DEPTH >= (1 << INDEX_W)) begin : g_direct
      assign addr_calc = AW'(index_ff);
   end else begin : g_reduce
      localparam int RECIP_SHIFT = 24;
      localparam int QPROD_W     = INDEX_W + RECIP_SHIFT;
      localparam int RECIP       = (1 << RECIP_SHIFT) / VERTEX_DEPTH;

      logic [QPROD_W-1:0]   quot_prod;
      logic [INDEX_W-1:0]   quot_in, quot_ff;
      logic [2*INDEX_W-1:0] quot_scaled;
      logic [INDEX_W:0]     rem_raw, rem_fix;

      assign quot_prod = QPROD_W'(index_ff) * QPROD_W'(RECIP);
      assign quot_in   = quot_prod[QPROD_W-1:RECIP_SHIFT];

      always_ff @(posedge clock) begin
         quot_ff <= quot_in;
      end

      // quotient estimate is low by at most one
      assign quot_scaled = (2*INDEX_W)'(quot_ff) * (2*INDEX_W)'(VERTEX_DEPTH);
      assign rem_raw     = {1'b0, index_ff} - quot_scaled[INDEX_W:0];
      assign rem_fix     = (rem_raw >= (INDEX_W+1)'(VERTEX_DEPTH)) ?
                           rem_raw - (INDEX_W+1)'(VERTEX_DEPTH) : rem_raw;
      assign addr_calc   = rem_fix[AW-1:0];
   end

   // store write back
   assign blended.x = blend_axis(ram_rdata.x, prod_x_ff);
   assign blended.y = blend_axis(ram_rdata.y, prod_y_ff);
   assign blended.z = blend_axis(ram_rdata.z, prod_z_ff);

   assign ram_we    = (state_ff == S_WRITE) || ((state_ff == S_MODIFY) && (op_ff == OP_APPLY));
   assign ram_wdata = (state_ff == S_WRITE) ? val_ff : blended;

   mtb_ram #(
      .WIDTH ($bits(pos_type)),
      .DEPTH (VERTEX_DEPTH)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (addr_ff),
      .write_data    (ram_wdata),
      .read_address  (addr_ff),
      .read_data     (ram_rdata)
   );

   // result register
   always_comb begin
      rsp_valid_in = (state_ff == S_MODIFY) && (op_ff == OP_READ);
      rsp_index_in = rsp_index_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (rsp_valid_in) begin
         rsp_index_in = index_ff;
         rsp_pos_in   = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WEIGHT_REGS; i++) begin
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      index_ff     <= index_in;
      wsel_ff      <= wsel_in;
      val_ff       <= val_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      prod_z_ff    <= prod_z_in;
      addr_ff      <= addr_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_pos_x      = rsp_pos_ff.x;
   assign rsp_pos_y      = rsp_pos_ff.y;
   assign rsp_pos_z      = rsp_pos_ff.z;

   `MTB_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `MTB_ASSERT_SAME(a_write_states, clock, reset, ram_we, (state_ff == S_WRITE) || (state_ff == S_MODIFY))
   `MTB_ASSERT_NEXT(a_read_returns, clock, reset, (state_ff == S_MODIFY) && (op_ff == OP_READ), rsp_valid)
   `MTB_ASSERT_NEXT(a_read_starts, clock, reset, start && !busy && (req_operation == OP_READ), state_ff == S_QUOT)

endmodule

`default_nettype wire

FILE: sv/mtb_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module mtb_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire
